// File: rtl/core/chol_pkg.sv
// Shared constants, types and helper functions of the upper Cholesky factor block.
`default_nettype none
package chol_pkg;

  localparam int MATRIX_DIM = 8;
  localparam int IDX_W      = 3;
  localparam int DEPTH      = MATRIX_DIM * MATRIX_DIM;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DATA_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int RAD_W      = DATA_W + FRAC_W;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int QUO_W      = DATA_W + FRAC_W;
  localparam int PROD_W     = 2 * DATA_W;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic signed [DATA_W-1:0] data_t;

  localparam idx_t LAST_IDX = IDX_W'(MATRIX_DIM - 1);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_DIAG_RD,
    ST_DIAG_CHK,
    ST_SQRT,
    ST_ROW_RD,
    ST_ROW_CHK,
    ST_DIV,
    ST_A_RD,
    ST_A_LD,
    ST_B_RD,
    ST_B_MUL,
    ST_C_WR,
    ST_OUT_RD,
    ST_OUT_LD
  } chol_state_t;

  // Linear store address of entry (r, c)
  function automatic addr_t addr_of(input idx_t r, input idx_t c);
    addr_of = ADDR_W'(int'(r) * MATRIX_DIM + int'(c));
  endfunction

  // Clamp a wide signed value to the 32-bit range
  function automatic data_t sat32(input logic signed [PROD_W-1:0] v);
    if ((&v[PROD_W-1:DATA_W-1]) || !(|v[PROD_W-1:DATA_W-1])) begin
      sat32 = v[DATA_W-1:0];
    end else if (v[PROD_W-1]) begin
      sat32 = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat32 = {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/chol_in_if.sv
// Input channel: one matrix element per transaction.
`default_nettype none
interface chol_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [chol_pkg::DATA_W-1:0] element_value;

  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface
`default_nettype wire

// File: rtl/core/chol_out_if.sv
// Result channel: one factor entry per transaction.
`default_nettype none
interface chol_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [chol_pkg::DATA_W-1:0] factor_value;
  logic [chol_pkg::IDX_W-1:0]         row_index;
  logic [chol_pkg::IDX_W-1:0]         col_index;
  logic                               failed;
  logic                               last_of_run;

  modport source (output valid, output factor_value, output row_index, output col_index,
                  output failed, output last_of_run, input ready);
  modport sink   (input valid, input factor_value, input row_index, input col_index,
                  input failed, input last_of_run, output ready);
endinterface
`default_nettype wire

// File: rtl/core/chol_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module chol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                      wdata,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// File: rtl/core/chol_sqrt.sv
// Iterative floor square root, two radicand bits per cycle.
`default_nettype none
module chol_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [chol_pkg::RAD_W-1:0]    radicand,
  output logic                               done,
  output logic [chol_pkg::ROOT_W-1:0]        root
);

  localparam int STEPS = chol_pkg::RAD_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);
  localparam int REM_W = chol_pkg::ROOT_W + 3;

  logic [chol_pkg::RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]            rem_r;
  logic [chol_pkg::ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]            cnt_r;
  logic                        run_r;
  logic                        done_r;
  logic [REM_W-1:0]            rem_sh;
  logic [REM_W-1:0]            trial;
  logic                        fits;

  // One digit of the restoring root recurrence
  always_comb begin
    rem_sh = {rem_r[REM_W-3:0], rad_r[chol_pkg::RAD_W-1 -: 2]};
    trial  = {1'b0, root_r, 2'b01};
    fits   = (rem_sh >= trial);
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (run_r) begin
      rad_r  <= {rad_r[chol_pkg::RAD_W-3:0], 2'b00};
      rem_r  <= fits ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[chol_pkg::ROOT_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

// File: rtl/core/chol_div.sv
// Iterative signed Q16.16 divide by a positive root, truncating, saturated.
`default_nettype none
module chol_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire chol_pkg::data_t               numer,
  input  wire logic [chol_pkg::ROOT_W-1:0]   divisor,
  output logic                               done,
  output chol_pkg::data_t                    quotient
);

  localparam int STEPS = chol_pkg::QUO_W;
  localparam int CNT_W = $clog2(STEPS + 1);
  localparam int DW    = chol_pkg::DATA_W;
  localparam int RW    = chol_pkg::ROOT_W;

  logic [chol_pkg::QUO_W-1:0] num_r;
  logic [RW-1:0]              rem_r;
  logic [RW-1:0]              div_r;
  logic                       neg_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       run_r;
  logic                       done_r;
  logic [DW-1:0]              mag;
  logic [RW:0]                rem_sh;
  logic                       fits;
  logic                       pos_ovf;
  logic                       neg_ovf;

  // Magnitude of the numerator
  assign mag = numer[DW-1] ? (~numer + 1'b1) : numer;

  // One bit of restoring division
  always_comb begin
    rem_sh = {rem_r, num_r[chol_pkg::QUO_W-1]};
    fits   = (rem_sh >= {1'b0, div_r});
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the numerator register collects quotient bits as it shifts out
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= {mag, {chol_pkg::FRAC_W{1'b0}}};
      rem_r <= '0;
      div_r <= divisor;
      neg_r <= numer[DW-1];
    end else if (run_r) begin
      num_r <= {num_r[chol_pkg::QUO_W-2:0], fits};
      rem_r <= fits ? RW'(rem_sh - {1'b0, div_r}) : RW'(rem_sh);
    end
  end

  // Sign and saturation of the finished magnitude
  always_comb begin
    pos_ovf = |num_r[chol_pkg::QUO_W-1:DW-1];
    neg_ovf = (|num_r[chol_pkg::QUO_W-1:DW]) || (num_r[DW-1] && (|num_r[DW-2:0]));
    if (neg_r) begin
      quotient = neg_ovf ? {1'b1, {(DW-1){1'b0}}} : (~num_r[DW-1:0] + 1'b1);
    end else begin
      quotient = pos_ovf ? {1'b0, {(DW-1){1'b1}}} : num_r[DW-1:0];
    end
  end

  assign done = done_r;

endmodule
`default_nettype wire

// File: rtl/core/cholesky_upper_factor.sv
// Top level: loads a matrix, factors it in place in one RAM and streams the upper factor.
// Load: one element per cycle, N*N transactions; the last one starts the factorisation.
// Factorisation: per pivot a root from the 24-step root unit and per off-diagonal entry
//   a divide by the 48-step divider, then per row an operand load and per trailing entry
//   a read, multiply and write-back; all single RAM port accesses. Ends early on failure.
// Emission: each entry is read from RAM, then loaded once the output register is free.
// Reset (synchronous, rst_n low): load position, state and output valid clear; RAM unreset.
`default_nettype none
module cholesky_upper_factor (
  input  wire logic  clk,
  input  wire logic  rst_n,
  chol_in_if.sink    in_chan,
  chol_out_if.source out_chan
);

  chol_pkg::chol_state_t state_r, state_nxt;
  chol_pkg::idx_t        k_r, i_r, j_r;
  logic                  failed_r;
  chol_pkg::data_t       a_r;
  logic signed [chol_pkg::PROD_W-1:0] prod_r;

  logic                          ram_we;
  chol_pkg::addr_t               ram_addr;
  logic [chol_pkg::DATA_W-1:0]   ram_wdata;
  logic [chol_pkg::DATA_W-1:0]   ram_rdata;
  chol_pkg::data_t               rd_s;

  logic                          sq_start, sq_done;
  logic [chol_pkg::ROOT_W-1:0]   sq_root;
  logic                          dv_start, dv_done;
  chol_pkg::data_t               dv_q;

  logic                          in_fire;
  logic                          diag_bad;
  logic signed [chol_pkg::PROD_W-1:0] diff;

  logic                          out_valid_r;
  chol_pkg::data_t               out_value_r;
  chol_pkg::idx_t                out_row_r, out_col_r;
  logic                          out_failed_r, out_last_r;

  assign rd_s     = ram_rdata;
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign diag_bad = (rd_s <= 0);
  assign diff     = chol_pkg::PROD_W'(rd_s) - (prod_r >>> chol_pkg::FRAC_W);

  chol_ram #(
    .WIDTH (chol_pkg::DATA_W),
    .DEPTH (chol_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  chol_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand ({ram_rdata, {chol_pkg::FRAC_W{1'b0}}}),
    .done     (sq_done),
    .root     (sq_root)
  );

  chol_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .numer    (rd_s),
    .divisor  (sq_root),
    .done     (dv_done),
    .quotient (dv_q)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      chol_pkg::ST_LOAD: begin
        if (in_fire && i_r == chol_pkg::LAST_IDX && j_r == chol_pkg::LAST_IDX) begin
          state_nxt = chol_pkg::ST_DIAG_RD;
        end
      end
      chol_pkg::ST_DIAG_RD:  state_nxt = chol_pkg::ST_DIAG_CHK;
      chol_pkg::ST_DIAG_CHK: state_nxt = diag_bad ? chol_pkg::ST_OUT_RD : chol_pkg::ST_SQRT;
      chol_pkg::ST_SQRT: begin
        if (sq_done) begin
          state_nxt = (k_r == chol_pkg::LAST_IDX) ? chol_pkg::ST_OUT_RD : chol_pkg::ST_ROW_RD;
        end
      end
      chol_pkg::ST_ROW_RD:  state_nxt = chol_pkg::ST_ROW_CHK;
      chol_pkg::ST_ROW_CHK: state_nxt = chol_pkg::ST_DIV;
      chol_pkg::ST_DIV: begin
        if (dv_done) begin
          state_nxt = (j_r == chol_pkg::LAST_IDX) ? chol_pkg::ST_A_RD : chol_pkg::ST_ROW_RD;
        end
      end
      chol_pkg::ST_A_RD:  state_nxt = chol_pkg::ST_A_LD;
      chol_pkg::ST_A_LD:  state_nxt = chol_pkg::ST_B_RD;
      chol_pkg::ST_B_RD:  state_nxt = chol_pkg::ST_B_MUL;
      chol_pkg::ST_B_MUL: state_nxt = chol_pkg::ST_C_WR;
      chol_pkg::ST_C_WR: begin
        if (j_r != chol_pkg::LAST_IDX) begin
          state_nxt = chol_pkg::ST_B_RD;
        end else if (i_r != chol_pkg::LAST_IDX) begin
          state_nxt = chol_pkg::ST_A_RD;
        end else begin
          state_nxt = chol_pkg::ST_DIAG_RD;
        end
      end
      chol_pkg::ST_OUT_RD: begin
        if (!out_valid_r || out_chan.ready) begin
          state_nxt = chol_pkg::ST_OUT_LD;
        end
      end
      chol_pkg::ST_OUT_LD: begin
        if (i_r == chol_pkg::LAST_IDX && j_r == chol_pkg::LAST_IDX) begin
          state_nxt = chol_pkg::ST_LOAD;
        end else begin
          state_nxt = chol_pkg::ST_OUT_RD;
        end
      end
      default: state_nxt = chol_pkg::ST_LOAD;
    endcase
  end

  // RAM port and unit starts; accesses are strictly one after another, so a write
  // always lands before the next read of the same entry
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wdata = '0;
    sq_start  = 1'b0;
    dv_start  = 1'b0;
    unique case (state_r)
      chol_pkg::ST_LOAD: begin
        ram_we    = in_fire;
        ram_addr  = chol_pkg::addr_of(i_r, j_r);
        ram_wdata = in_chan.element_value;
      end
      chol_pkg::ST_DIAG_RD:  ram_addr = chol_pkg::addr_of(k_r, k_r);
      chol_pkg::ST_DIAG_CHK: sq_start = !diag_bad;
      chol_pkg::ST_SQRT: begin
        ram_we    = sq_done;
        ram_addr  = chol_pkg::addr_of(k_r, k_r);
        ram_wdata = chol_pkg::DATA_W'(sq_root);
      end
      chol_pkg::ST_ROW_RD:  ram_addr = chol_pkg::addr_of(k_r, j_r);
      chol_pkg::ST_ROW_CHK: dv_start = 1'b1;
      chol_pkg::ST_DIV: begin
        ram_we    = dv_done;
        ram_addr  = chol_pkg::addr_of(k_r, j_r);
        ram_wdata = dv_q;
      end
      chol_pkg::ST_A_RD:  ram_addr = chol_pkg::addr_of(k_r, i_r);
      chol_pkg::ST_A_LD:  ram_addr = '0;
      chol_pkg::ST_B_RD:  ram_addr = chol_pkg::addr_of(k_r, j_r);
      chol_pkg::ST_B_MUL: ram_addr = chol_pkg::addr_of(i_r, j_r);
      chol_pkg::ST_C_WR: begin
        ram_we    = 1'b1;
        ram_addr  = chol_pkg::addr_of(i_r, j_r);
        ram_wdata = chol_pkg::sat32(diff);
      end
      chol_pkg::ST_OUT_RD: ram_addr = chol_pkg::addr_of(i_r, j_r);
      chol_pkg::ST_OUT_LD: ram_addr = '0;
      default: ram_we = 1'b0;
    endcase
  end

  // State, loop indices and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= chol_pkg::ST_LOAD;
      k_r      <= '0;
      i_r      <= '0;
      j_r      <= '0;
      failed_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        chol_pkg::ST_LOAD, chol_pkg::ST_OUT_LD: begin
          if (state_r == chol_pkg::ST_OUT_LD || in_fire) begin
            if (j_r == chol_pkg::LAST_IDX) begin
              j_r <= '0;
              i_r <= (i_r == chol_pkg::LAST_IDX) ? '0 : i_r + 1'b1;
            end else begin
              j_r <= j_r + 1'b1;
            end
          end
          if (state_r == chol_pkg::ST_LOAD) begin
            k_r      <= '0;
            failed_r <= 1'b0;
          end
        end
        chol_pkg::ST_DIAG_CHK: begin
          if (diag_bad) begin
            failed_r <= 1'b1;
            i_r      <= '0;
            j_r      <= '0;
          end
        end
        chol_pkg::ST_SQRT: begin
          if (sq_done) begin
            if (k_r == chol_pkg::LAST_IDX) begin
              i_r <= '0;
              j_r <= '0;
            end else begin
              j_r <= k_r + 1'b1;
            end
          end
        end
        chol_pkg::ST_DIV: begin
          if (dv_done) begin
            if (j_r == chol_pkg::LAST_IDX) begin
              i_r <= k_r + 1'b1;
            end else begin
              j_r <= j_r + 1'b1;
            end
          end
        end
        chol_pkg::ST_A_LD: j_r <= i_r;
        chol_pkg::ST_C_WR: begin
          if (j_r != chol_pkg::LAST_IDX) begin
            j_r <= j_r + 1'b1;
          end else if (i_r != chol_pkg::LAST_IDX) begin
            i_r <= i_r + 1'b1;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        default: k_r <= k_r;
      endcase
    end
  end

  // Pivot-row operand and product register
  always_ff @(posedge clk) begin
    if (state_r == chol_pkg::ST_A_LD) begin
      a_r <= rd_s;
    end
    if (state_r == chol_pkg::ST_B_MUL) begin
      prod_r <= a_r * rd_s;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == chol_pkg::ST_OUT_LD) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == chol_pkg::ST_OUT_LD) begin
      out_value_r  <= (failed_r || j_r < i_r) ? '0 : rd_s;
      out_row_r    <= i_r;
      out_col_r    <= j_r;
      out_failed_r <= failed_r;
      out_last_r   <= (i_r == chol_pkg::LAST_IDX) && (j_r == chol_pkg::LAST_IDX);
    end
  end

  assign in_chan.ready         = (state_r == chol_pkg::ST_LOAD);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.factor_value = out_value_r;
  assign out_chan.row_index    = out_row_r;
  assign out_chan.col_index    = out_col_r;
  assign out_chan.failed       = out_failed_r;
  assign out_chan.last_of_run  = out_last_r;

endmodule
`default_nettype wire

// File: rtl/core/chol_checker.sv
// Port-level checks of the upper Cholesky factor block and their bind.
`default_nettype none
module chol_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire chol_pkg::data_t            factor_value,
  input wire chol_pkg::idx_t             row_index,
  input wire chol_pkg::idx_t             col_index,
  input wire logic                       failed,
  input wire logic                       last_of_run
);

  // A stalled result transaction stays valid and keeps its value and indices
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(factor_value) && $stable(row_index)
      && $stable(col_index))
    else $error("result changed while stalled");

  // Failed runs carry zero values
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && failed |-> factor_value == '0)
    else $error("failed run with nonzero value");

  // Lower triangle is zero
  a_lower_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && col_index < row_index |-> factor_value == '0)
    else $error("nonzero entry below diagonal");

  // No loading while a run is still being streamed out
  a_no_load_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_of_run |-> !in_ready)
    else $error("input taken in the middle of a run");

endmodule

bind cholesky_upper_factor chol_checker u_chol_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .factor_value (out_chan.factor_value),
  .row_index    (out_chan.row_index),
  .col_index    (out_chan.col_index),
  .failed       (out_chan.failed),
  .last_of_run  (out_chan.last_of_run)
);
`default_nettype wire
